@@ src/gdil_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdil_pkg
// Types, constants and small pixel helpers shared by the geodesic dilation
// pass and its line store banks.
// ----------------------------------------------------------------------------
package gdil_pkg;

	localparam int PIX_W       = 8;
	localparam int COORD_W     = 11;
	localparam int CFG_W       = 12;
	localparam int SIZE_RESET  = 512;
	localparam int MAX_RESULTS = 4;
	localparam int CFG_IDX_W   = 1;

	typedef logic [PIX_W-1:0]     pixel_t;
	typedef logic [COORD_W-1:0]   coord_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// One line store entry: horizontal values of the two previous rows and
	// the mask pixel of the row above.
	typedef struct packed {
		pixel_t older;
		pixel_t newer;
		pixel_t mask_above;
	} line_word_t;

	typedef struct packed {
		pixel_t pix;
		coord_t col;
		coord_t row;
	} result_t;

	function automatic pixel_t max_pix(input pixel_t a, input pixel_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pixel_t min_pix(input pixel_t a, input pixel_t b);
		return (a < b) ? a : b;
	endfunction

endpackage
`default_nettype wire

@@ src/gdil_line_bank.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdil_line_bank
// One bank of the line store: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module gdil_line_bank #(
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                  clk,
	input  wire                  wr_en,
	input  wire  [AW-1:0]        wr_addr,
	input  gdil_pkg::line_word_t wr_data,
	input  wire                  rd_en,
	input  wire  [AW-1:0]        rd_addr,
	output gdil_pkg::line_word_t rd_data
);
	import gdil_pkg::*;

	line_word_t mem_q [0:DEPTH-1];
	line_word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ src/geodesic_dilation_3x3_pass.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: an input is registered in stage 1; its results then go to the result buffer.
// Throughput: one input per cycle while the result buffer is free; the k results
//   of an input take k transfers (up to two on the last row, four at its end).
// Reset: position counters, marker window and left mask clear, sizes go to
//   512; line store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// geodesic_dilation_3x3_pass
// One raster pass of 3x3 grayscale geodesic dilation. Line stores are split
// into even and odd column banks so the two columns finished at a row end
// are read together and written together.
// ----------------------------------------------------------------------------
module geodesic_dilation_3x3_pass #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_write_enable,
	input  gdil_pkg::cfg_index_t cfg_index,
	input  gdil_pkg::cfg_data_t  cfg_data,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  gdil_pkg::pixel_t     mask_pixel,
	input  gdil_pkg::pixel_t     marker_pixel,
	output logic                 out_valid,
	input  wire                  out_stall,
	output gdil_pkg::pixel_t     result_pixel,
	output gdil_pkg::coord_t     out_column,
	output gdil_pkg::coord_t     out_row,
	output logic                 run_last
);
	import gdil_pkg::*;

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int RW         = $clog2(MAX_HEIGHT);
	localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int PTR_W      = $clog2(MAX_RESULTS);

	localparam logic [CW-1:0] LAST_COL_RESET =
		CW'(((MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET) - 1);
	localparam logic [RW-1:0] LAST_ROW_RESET =
		RW'(((MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET) - 1);

	// ------------------------------------------------------------------
	// Configuration: store the last column / row index, already clamped
	// ------------------------------------------------------------------
	logic [CW-1:0] last_col_q, last_col_d;
	logic [RW-1:0] last_row_q, last_row_d;

	always_comb begin
		if (cfg_data == '0) begin
			last_col_d = '0;
			last_row_d = '0;
		end else begin
			last_col_d = (int'(cfg_data) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1)
				: CW'(int'(cfg_data) - 1);
			last_row_d = (int'(cfg_data) > MAX_HEIGHT) ? RW'(MAX_HEIGHT - 1)
				: RW'(int'(cfg_data) - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= LAST_COL_RESET;
			last_row_q <= LAST_ROW_RESET;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  last_col_q <= last_col_d;
				REG_IMAGE_HEIGHT: last_row_q <= last_row_d;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input side: position, marker window, line store reads
	// ------------------------------------------------------------------
	logic          in_accept;
	logic [CW-1:0] col_q, c_in, col_a_in;
	logic [RW-1:0] row_q, r_in;
	logic          end_in, last_in, has_a_in;
	pixel_t        marker_win0_q, marker_win1_q, mask_left_q;
	pixel_t        w0_in, w1_in;

	assign in_accept = in_valid && !in_stall;
	assign c_in      = (col_q < last_col_q) ? col_q : last_col_q;
	assign r_in      = (row_q < last_row_q) ? row_q : last_row_q;
	assign end_in    = (c_in == last_col_q);
	assign last_in   = (r_in == last_row_q);
	assign has_a_in  = (c_in != '0);
	assign col_a_in  = c_in - 1'b1;
	assign w0_in     = has_a_in ? marker_win0_q : marker_pixel;
	assign w1_in     = has_a_in ? marker_win1_q : marker_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			marker_win0_q <= '0;
			marker_win1_q <= '0;
			mask_left_q   <= '0;
		end else if (in_accept) begin
			marker_win1_q <= w0_in;
			marker_win0_q <= marker_pixel;
			mask_left_q   <= mask_pixel;
			if (end_in) begin
				col_q <= '0;
				row_q <= last_in ? '0 : r_in + 1'b1;
			end else begin
				col_q <= c_in + 1'b1;
				row_q <= r_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 registers
	// ------------------------------------------------------------------
	logic          s1_valid_q, s1_adv;
	logic [CW-1:0] c_s1, col_a_s1;
	logic [RW-1:0] r_s1;
	logic          end_s1, last_s1, has_a_s1;
	pixel_t        m_s1, j_s1, w0_s1, w1_s1, mask_left_s1;
	logic          fwd_s1    [2];
	line_word_t    fwd_word_s1 [2];

	// Bank ports
	logic               rd_en   [2];
	logic [BANK_AW-1:0] rd_addr [2];
	line_word_t         rd_data [2];
	logic               wr_en   [2];
	logic [BANK_AW-1:0] wr_addr [2];
	line_word_t         wr_data [2];
	logic               fwd_d   [2];
	line_word_t         word_a_new, word_b_new;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rd_en[k] = in_accept && ((has_a_in && col_a_in[0] == 1'(k))
				|| (end_in && c_in[0] == 1'(k)));
			rd_addr[k] = (has_a_in && col_a_in[0] == 1'(k)) ? BANK_AW'(col_a_in >> 1)
				: BANK_AW'(c_in >> 1);
			wr_en[k] = s1_adv && ((has_a_s1 && col_a_s1[0] == 1'(k))
				|| (end_s1 && c_s1[0] == 1'(k)));
			if (has_a_s1 && col_a_s1[0] == 1'(k)) begin
				wr_addr[k] = BANK_AW'(col_a_s1 >> 1);
				wr_data[k] = word_a_new;
			end else begin
				wr_addr[k] = BANK_AW'(c_s1 >> 1);
				wr_data[k] = word_b_new;
			end
			// The item in stage 1 writes while the new item reads the same entry
			fwd_d[k] = wr_en[k] && rd_en[k] && (wr_addr[k] == rd_addr[k]);
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_bank
		gdil_line_bank #(
			.DEPTH (BANK_DEPTH),
			.AW    (BANK_AW)
		) u_bank (
			.clk     (clk),
			.wr_en   (wr_en[g]),
			.wr_addr (wr_addr[g]),
			.wr_data (wr_data[g]),
			.rd_en   (rd_en[g]),
			.rd_addr (rd_addr[g]),
			.rd_data (rd_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			c_s1         <= c_in;
			col_a_s1     <= col_a_in;
			r_s1         <= r_in;
			end_s1       <= end_in;
			last_s1      <= last_in;
			has_a_s1     <= has_a_in;
			m_s1         <= mask_pixel;
			j_s1         <= marker_pixel;
			w0_s1        <= w0_in;
			w1_s1        <= w1_in;
			mask_left_s1 <= mask_left_q;
			for (int k = 0; k < 2; k++) begin
				fwd_s1[k]      <= fwd_d[k];
				fwd_word_s1[k] <= wr_data[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 compute: two finished columns, up to four results
	// ------------------------------------------------------------------
	line_word_t ent [2];
	line_word_t ent_a, ent_b;
	pixel_t     hv_a, hv_b, res_aa, res_ab, res_ba, res_bb;
	result_t    cand   [MAX_RESULTS];
	logic       cand_v [MAX_RESULTS];
	result_t    packed_res [MAX_RESULTS];
	logic [CNT_W-1:0] n_res;
	coord_t     col_a_o, col_b_o, row_up_o, row_o;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			ent[k] = fwd_s1[k] ? fwd_word_s1[k] : rd_data[k];
		end
		ent_a = ent[col_a_s1[0]];
		ent_b = ent[c_s1[0]];

		hv_a = min_pix(mask_left_s1, max_pix(w1_s1, max_pix(w0_s1, j_s1)));
		hv_b = min_pix(m_s1, max_pix(w0_s1, j_s1));

		res_aa = min_pix(ent_a.mask_above, max_pix((r_s1 > RW'(1)) ? ent_a.older
			: ent_a.newer, max_pix(ent_a.newer, hv_a)));
		res_ba = min_pix(ent_b.mask_above, max_pix((r_s1 > RW'(1)) ? ent_b.older
			: ent_b.newer, max_pix(ent_b.newer, hv_b)));
		res_ab = min_pix(mask_left_s1, max_pix((r_s1 != '0) ? ent_a.newer : hv_a, hv_a));
		res_bb = min_pix(m_s1, max_pix((r_s1 != '0) ? ent_b.newer : hv_b, hv_b));

		word_a_new = '{older: ent_a.newer, newer: hv_a, mask_above: mask_left_s1};
		word_b_new = '{older: ent_b.newer, newer: hv_b, mask_above: m_s1};

		col_a_o  = COORD_W'(col_a_s1);
		col_b_o  = COORD_W'(c_s1);
		row_up_o = COORD_W'(RW'(r_s1 - 1'b1));
		row_o    = COORD_W'(r_s1);

		// Row above first, then the last row, each in column order
		cand[0]   = '{pix: res_aa, col: col_a_o, row: row_up_o};
		cand_v[0] = has_a_s1 && (r_s1 != '0);
		cand[1]   = '{pix: res_ba, col: col_b_o, row: row_up_o};
		cand_v[1] = end_s1 && (r_s1 != '0);
		cand[2]   = '{pix: res_ab, col: col_a_o, row: row_o};
		cand_v[2] = has_a_s1 && last_s1;
		cand[3]   = '{pix: res_bb, col: col_b_o, row: row_o};
		cand_v[3] = end_s1 && last_s1;

		n_res = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			packed_res[i] = cand[i];
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (cand_v[i]) begin
				packed_res[n_res[PTR_W-1:0]] = cand[i];
				n_res = n_res + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result buffer: serialize up to four results per input
	// ------------------------------------------------------------------
	result_t          buf_q [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] ptr_q;
	logic             out_fire, buf_last, buf_free, buf_load;

	assign out_valid = (cnt_q != '0);
	assign out_fire  = out_valid && !out_stall;
	assign buf_last  = (CNT_W'(ptr_q) == cnt_q - 1'b1);
	assign buf_free  = (cnt_q == '0) || (out_fire && buf_last);
	assign s1_adv    = s1_valid_q && ((n_res == '0) || buf_free);
	assign buf_load  = s1_adv && (n_res != '0);
	assign in_stall  = s1_valid_q && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (buf_load) begin
			cnt_q <= n_res;
			ptr_q <= '0;
		end else if (out_fire) begin
			if (buf_last) begin
				cnt_q <= '0;
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_q[i] <= packed_res[i];
			end
		end
	end

	assign result_pixel = buf_q[ptr_q].pix;
	assign out_column   = buf_q[ptr_q].col;
	assign out_row      = buf_q[ptr_q].row;
	assign run_last     = buf_last;

endmodule
`default_nettype wire

@@ test/geodesic_dilation_3x3_pass_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodesic_dilation_3x3_pass_tb
// Streams mask and marker pixels through one reconstruction pass and checks
// every result against a cycle-free model of the 3x3 dilation, its line
// stores and its frame position. A short table of hand-picked pixels and
// sizes comes first, then random frames of many shapes with random gaps and
// output stalls, one long output hold-off, and saturated sizes cut short by
// a shrink partway through the frame.
// ----------------------------------------------------------------------------
module geodesic_dilation_3x3_pass_tb;
	import gdil_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int QUIET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 20;
	localparam int GAP_MAX       = 17;
	localparam int HOLD_CYCLES   = 300;
	localparam int RAND_ITEMS    = 360;
	localparam int SAT_ITEMS     = 24;
	localparam int COL_MAX       = 2048;
	localparam int ROW_MAX       = 2048;
	localparam int PLAN_ROWS     = 28;

	typedef struct packed {
		pixel_t pix;
		coord_t col;
		coord_t row;
		logic   last;
	} pixel_out_t;

	typedef enum bit {ROW_PIX, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cfg_reg_t  sel;
		int        value;
		pixel_t    mask;
		pixel_t    marker;
		bit        known;
		pixel_t    want_pix;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_write_enable;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;
	logic       in_valid;
	logic       in_stall;
	pixel_t     mask_pixel;
	pixel_t     marker_pixel;
	logic       out_valid;
	logic       out_stall;
	pixel_t     result_pixel;
	coord_t     out_column;
	coord_t     out_row;
	logic       run_last;

	// sender and receiver controls
	bit     tx_idle_on;
	bit     rx_idle_on;
	int     holds_asked;
	bit     row_known;
	pixel_t row_expect;
	int     mismatches;
	int     cycle_count;

	// dilation model state
	int         frame_w = SIZE_RESET;
	int         frame_h = SIZE_RESET;
	int         col_pos = 0;
	int         row_pos = 0;
	pixel_t     win_near = '0;
	pixel_t     win_far = '0;
	pixel_t     mask_left = '0;
	pixel_t     hmax_prev2 [COL_MAX];
	pixel_t     hmax_prev1 [COL_MAX];
	pixel_t     mask_above [COL_MAX];
	pixel_out_t due_pixels [$];

	// 1x1 frames give min(mask, marker), so those rows carry the value
	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd10,  8'd20,  1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd30,  8'd40,  1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd50,  8'd60,  1'b0, 8'd0},
		'{ROW_CFG, REG_IMAGE_WIDTH,  4, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 2, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd255, 8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd0,   8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd255, 8'd255, 1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd128, 8'd1,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd7,   8'd200, 1'b0, 8'd0},
		'{ROW_CFG, REG_IMAGE_WIDTH,  0, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 0, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd255, 8'd0,   1'b1, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd0,   8'd255, 1'b1, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd255, 8'd255, 1'b1, 8'd255},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd0,   8'd0,   1'b1, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd200, 8'd100, 1'b1, 8'd100},
		'{ROW_CFG, REG_IMAGE_WIDTH,  2, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 5, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd1,   8'd254, 1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd254, 8'd1,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd170, 8'd85,  1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd85,  8'd170, 1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd240, 8'd15,  1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd15,  8'd240, 1'b0, 8'd0},
		// shrink the frame while on row 3: the row is clamped and ends it
		'{ROW_CFG, REG_IMAGE_HEIGHT, 2, 8'd0,   8'd0,   1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd99,  8'd33,  1'b0, 8'd0},
		'{ROW_PIX, REG_IMAGE_WIDTH,  0, 8'd33,  8'd99,  1'b0, 8'd0}
	};

	geodesic_dilation_3x3_pass dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mask_pixel       (mask_pixel),
		.marker_pixel     (marker_pixel),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_pixel     (result_pixel),
		.out_column       (out_column),
		.out_row          (out_row),
		.run_last         (run_last)
	);

	always #10 clk = ~clk;

	function automatic pixel_t pmax(input pixel_t a, input pixel_t b);
		return (a >= b) ? a : b;
	endfunction

	function automatic pixel_t pmin(input pixel_t a, input pixel_t b);
		return (a <= b) ? a : b;
	endfunction

	function automatic int fit_size(input int value, input int bound);
		int v;
		v = value & 12'hFFF;
		if (v == 0) return 1;
		if (v > bound) return bound;
		return v;
	endfunction

	// Retire a finished horizontal value at column x: produce the result of
	// the row above, if any, and, on the last row, the result of this row too.
	function automatic void close_column(input int x, input int r, input bit last_row,
			input pixel_t hv, input pixel_t m, output bit has_up, output pixel_t up_pix,
			output bit has_low, output pixel_t low_pix);
		pixel_t older;
		pixel_t newer;
		pixel_t above;
		pixel_t top;
		older   = hmax_prev2[x];
		newer   = hmax_prev1[x];
		above   = mask_above[x];
		has_up  = (r >= 1);
		has_low = last_row;
		up_pix  = '0;
		low_pix = '0;
		if (r >= 1) begin
			top    = (r >= 2) ? older : newer;
			up_pix = pmin(above, pmax(top, pmax(newer, hv)));
		end
		if (last_row) begin
			top     = (r >= 1) ? newer : hv;
			low_pix = pmin(m, pmax(top, hv));
		end
		hmax_prev2[x] = newer;
		hmax_prev1[x] = hv;
		mask_above[x] = m;
	endfunction

	function automatic void dilate_step(input pixel_t m, input pixel_t j);
		int         c;
		int         r;
		bit         row_end;
		bit         last_row;
		bit         ua;
		bit         la;
		bit         ub;
		bit         lb;
		pixel_t     pa;
		pixel_t     qa;
		pixel_t     pb;
		pixel_t     qb;
		pixel_t     hv;
		pixel_out_t batch [$];
		c        = (col_pos < frame_w - 1) ? col_pos : frame_w - 1;
		r        = (row_pos < frame_h - 1) ? row_pos : frame_h - 1;
		row_end  = (c == frame_w - 1);
		last_row = (r == frame_h - 1);
		{ua, la, ub, lb} = '0;
		if (c == 0) begin
			win_near = j;
			win_far  = j;
		end
		if (c >= 1) begin
			hv = pmin(mask_left, pmax(win_far, pmax(win_near, j)));
			close_column(c - 1, r, last_row, hv, mask_left, ua, pa, la, qa);
		end
		if (row_end) begin
			hv = pmin(m, pmax(win_near, j));
			close_column(c, r, last_row, hv, m, ub, pb, lb, qb);
		end
		// row above first, then the last row, each left to right
		if (ua) batch.push_back('{pix: pa, col: coord_t'(c - 1), row: coord_t'(r - 1), last: 1'b0});
		if (ub) batch.push_back('{pix: pb, col: coord_t'(c), row: coord_t'(r - 1), last: 1'b0});
		if (la) batch.push_back('{pix: qa, col: coord_t'(c - 1), row: coord_t'(r), last: 1'b0});
		if (lb) batch.push_back('{pix: qb, col: coord_t'(c), row: coord_t'(r), last: 1'b0});
		if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k]) due_pixels.push_back(batch[k]);
		win_far   = win_near;
		win_near  = j;
		mask_left = m;
		if (row_end) begin
			col_pos = 0;
			row_pos = last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic pixel_t any_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 8'hFF;
			default: return pixel_t'($urandom_range(0, 255));
		endcase
	endfunction

	always @(posedge clk) begin : watch_ports
		pixel_out_t want;
		int         tail;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				dilate_step(mask_pixel, marker_pixel);
				if (row_known && due_pixels.size() != 0) begin
					tail = due_pixels.size() - 1;
					due_pixels[tail].pix = row_expect;
				end
			end
			if (out_valid && !out_stall) begin
				if (due_pixels.size() == 0) begin
					$error("unexpected result: pixel %0d at column %0d row %0d",
						result_pixel, out_column, out_row);
					mismatches++;
				end else begin
					want = due_pixels.pop_front();
					check_field("result_pixel", want.pix, result_pixel);
					check_field("out_column", want.col, out_column);
					check_field("out_row", want.row, out_row);
					check_field("run_last", want.last, run_last);
				end
			end
		end
	end

	task automatic send_item(input pixel_t m, input pixel_t j, input bit known,
			input pixel_t want_pix);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		mask_pixel   = m;
		marker_pixel = j;
		row_known    = known;
		row_expect   = want_pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_item(any_pixel(), any_pixel(), 1'b0, '0);
	endtask

	// Drop valid, let every pending result out, then give the pipe time to empty.
	task automatic drain_and_rest();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input cfg_reg_t sel, input int value);
		@(negedge clk);
		cfg_write_enable = 1'b1;
		cfg_index        = sel;
		cfg_data         = cfg_data_t'(value);
		if (sel == REG_IMAGE_WIDTH) frame_w = fit_size(value, COL_MAX);
		else frame_h = fit_size(value, ROW_MAX);
		@(negedge clk);
		cfg_write_enable = 1'b0;
	endtask

	initial begin : drain_results
		int stall_len;
		int holds_served;
		holds_served = 0;
		out_stall    = 1'b0;
		forever begin
			if (holds_asked != holds_served) begin
				stall_len    = HOLD_CYCLES;
				holds_served = holds_asked;
			end else begin
				stall_len = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
			end
			repeat (stall_len) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int i;
		int w;
		int h;
		int frames;
		int part;
		int c;
		int r;
		int rest;
		int sent;
		int phase;
		in_valid         = 1'b0;
		mask_pixel       = '0;
		marker_pixel     = '0;
		cfg_write_enable = 1'b0;
		cfg_index        = REG_IMAGE_WIDTH;
		cfg_data         = '0;
		row_known        = 1'b0;
		row_expect       = '0;
		tx_idle_on       = 1'b1;
		rx_idle_on       = 1'b1;
		holds_asked      = 0;
		mismatches       = 0;
		arst_n           = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].kind == ROW_CFG) begin
				drain_and_rest();
				write_size(plan[i].sel, plan[i].value);
			end else begin
				send_item(plan[i].mask, plan[i].marker, plan[i].known, plan[i].want_pix);
			end
		end

		sent  = 0;
		phase = 0;
		// always reach the held-off phase, however large the early frames are
		while (sent < RAND_ITEMS || phase <= 3) begin
			if (phase == 3) begin
				w = 10;
				h = 8;
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 8);
			end
			drain_and_rest();
			// a size of one is written as zero half the time
			write_size(REG_IMAGE_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 0 : w);
			write_size(REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? 0 : h);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 3) begin
				// keep offering while the output is held so the input backs up
				tx_idle_on  = 1'b0;
				holds_asked = holds_asked + 1;
			end
			frames = $urandom_range(1, 3);
			send_random(frames * w * h);
			sent += frames * w * h;
			if (w * h >= 2 && $urandom_range(0, 3) == 0) begin
				// stop partway through a frame and shrink it before finishing
				part = $urandom_range(1, w * h - 1);
				send_random(part);
				drain_and_rest();
				write_size(REG_IMAGE_WIDTH, $urandom_range(1, w));
				write_size(REG_IMAGE_HEIGHT, $urandom_range(1, h));
				c    = (col_pos < frame_w - 1) ? col_pos : frame_w - 1;
				r    = (row_pos < frame_h - 1) ? row_pos : frame_h - 1;
				rest = (frame_h - 1 - r) * frame_w + (frame_w - c);
				send_random(rest);
				sent += part + rest;
			end
			phase++;
		end

		// saturated register values, then shrink to end the frame early
		drain_and_rest();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		write_size(REG_IMAGE_WIDTH, 4095);
		write_size(REG_IMAGE_HEIGHT, 0);
		send_random(SAT_ITEMS);
		drain_and_rest();
		write_size(REG_IMAGE_WIDTH, SAT_ITEMS + 1);
		send_random(1);
		drain_and_rest();
		write_size(REG_IMAGE_WIDTH, 0);
		write_size(REG_IMAGE_HEIGHT, 4095);
		send_random(SAT_ITEMS);
		drain_and_rest();
		write_size(REG_IMAGE_HEIGHT, SAT_ITEMS + 1);
		send_random(1);

		drain_and_rest();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/gdil_pkg.sv
src/gdil_line_bank.sv
src/geodesic_dilation_3x3_pass.sv
test/geodesic_dilation_3x3_pass_tb.sv
